[rtl/crlru_pkg.sv]
// Shared constants, types and helpers for the LRU age-rank replacement block.
`default_nettype none

package crlru_pkg;

   // Cache geometry. SETS must be a power of two no larger than the set field covers.
   localparam int SETS   = 1024;
   localparam int WAYS   = 16;
   localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int RANK_W = $clog2(WAYS);
   localparam int ROW_W  = WAYS * RANK_W;

   // Field widths of the request and response beats.
   localparam int KIND_W = 2;
   localparam int SIDX_W = 10;
   localparam int WAY_W  = 4;
   localparam int MASK_W = 16;

   // Operation codes carried in req_kind.
   localparam logic [KIND_W-1:0] KIND_TOUCH  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEMOTE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_VICTIM = 2'd2;

   typedef logic [RANK_W-1:0] rank_type;
   typedef rank_type [WAYS-1:0] row_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic update;
      logic load_rsp;
   } crlru_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic is_victim;
   } crlru_sts_type;

   // Rank row after reset: way w holds rank w.
   function automatic row_type init_row();
      row_type row;
      for (int w = 0; w < WAYS; w++) begin
         row[w] = RANK_W'(w);
      end
      return row;
   endfunction

endpackage

`default_nettype wire

[rtl/cache_lru_counter_replacement.sv]
// Top level of the true-LRU age-rank replacement block.
//
// Usage: each request beat (req_kind, req_set_index, req_way, req_valid_mask)
// names one set of the cache. A touch makes req_way the most recent way, a
// demote makes it the least recent way, and a victim query picks the least
// recent way, makes it most recent and returns one response beat
// (rsp_victim_way, rsp_evicted). Touch and demote return nothing; an unused
// kind or an out-of-range way leaves the ranks unchanged.
// A beat moves when valid is high and stall is low on its channel.
// Each request has a read step, which reads the set's rank row from the rank
// memory, and an update step, which updates the row and writes it back;
// req_stall stays high in the update step, so the block takes no new request
// before the last one is through. A victim query's response is loaded into
// the output register in its update step, once that register is free.
// After reset the block runs a clearing pass that writes the initial ranks
// into every set; req_stall stays high meanwhile.
// While rsp_stall holds a waiting response, touches and demotes continue;
// a further victim query waits in its update step until the register frees.
`default_nettype none

module cache_lru_counter_replacement
   import crlru_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [KIND_W-1:0] req_kind,
   input  wire logic [SIDX_W-1:0] req_set_index,
   input  wire logic [WAY_W-1:0]  req_way,
   input  wire logic [MASK_W-1:0] req_valid_mask,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [WAY_W-1:0]  rsp_victim_way,
   output logic                   rsp_evicted
);

   crlru_cmd_type cmd;
   crlru_sts_type sts;

   crlru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   crlru_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_kind       (req_kind),
      .req_set_index  (req_set_index),
      .req_way        (req_way),
      .req_valid_mask (req_valid_mask),
      .rsp_victim_way (rsp_victim_way),
      .rsp_evicted    (rsp_evicted)
   );

endmodule

`default_nettype wire

[rtl/crlru_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module crlru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/crlru_datapath.sv]
// Datapath: rank memory, request capture, rank update and response payload register.
`default_nettype none

module crlru_datapath
   import crlru_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire crlru_cmd_type       cmd,
   output crlru_sts_type            sts,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic [SIDX_W-1:0]   req_set_index,
   input  wire logic [WAY_W-1:0]    req_way,
   input  wire logic [MASK_W-1:0]   req_valid_mask,
   output logic      [WAY_W-1:0]    rsp_victim_way,
   output logic                     rsp_evicted
);

   logic [SET_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [KIND_W-1:0] kind_ff;
   logic [SET_W-1:0]  set_ff;
   logic [WAY_W-1:0]  way_ff;
   logic [MASK_W-1:0] mask_ff;
   logic [WAY_W-1:0]  victim_way_ff;
   logic              evicted_ff;

   row_type           rd_row;
   row_type           new_row;
   row_type           wr_row;
   logic [ROW_W-1:0]  rd_bits;
   logic [SET_W-1:0]  wr_addr;
   logic              wr_en;
   logic              way_ok;
   logic              wr_ok;
   logic              is_victim;
   logic              make_mru;
   rank_type          victim;
   rank_type          target;
   rank_type          old_rank;
   logic [MASK_W-1:0] mask_shift;

   // Clearing pass address counter.
   assign clr_addr_in = cmd.clear_step ? clr_addr_ff + SET_W'(1) : clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Capture the request beat when it is accepted.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         set_ff  <= SET_W'(req_set_index);
         way_ff  <= req_way;
         mask_ff <= req_valid_mask;
      end
   end

   // Victim search: the highest way whose rank is the oldest.
   always_comb begin
      victim = '0;
      for (int j = 0; j < WAYS; j++) begin
         if (rd_row[j] == RANK_W'(WAYS - 1)) begin
            victim = RANK_W'(j);
         end
      end
   end

   assign rd_row    = row_type'(rd_bits);
   assign is_victim = (kind_ff == KIND_VICTIM);
   assign make_mru  = (kind_ff == KIND_TOUCH) || is_victim;
   assign way_ok    = (32'(way_ff) < WAYS);
   assign wr_ok     = is_victim ||
                      (((kind_ff == KIND_TOUCH) || (kind_ff == KIND_DEMOTE)) && way_ok);
   assign target    = is_victim ? victim : RANK_W'(way_ff);
   assign old_rank  = rd_row[target];

   // Rank update: all ways in parallel against the target's old rank.
   always_comb begin
      for (int j = 0; j < WAYS; j++) begin
         if (RANK_W'(j) == target) begin
            new_row[j] = make_mru ? '0 : RANK_W'(WAYS - 1);
         end else if (make_mru && (rd_row[j] < old_rank)) begin
            new_row[j] = rd_row[j] + RANK_W'(1);
         end else if (!make_mru && (rd_row[j] > old_rank)) begin
            new_row[j] = rd_row[j] - RANK_W'(1);
         end else begin
            new_row[j] = rd_row[j];
         end
      end
   end

   // Write port: clearing pass or write-back of the updated row.
   assign wr_en   = cmd.clear_step || (cmd.update && wr_ok);
   assign wr_addr = cmd.clear_step ? clr_addr_ff : set_ff;
   assign wr_row  = cmd.clear_step ? init_row() : new_row;

   crlru_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ROW_W'(wr_row)),
      .rd_en   (cmd.capture),
      .rd_addr (SET_W'(req_set_index)),
      .rd_data (rd_bits)
   );

   // Response payload; a line beyond the mask counts as invalid.
   assign mask_shift = mask_ff >> victim;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         victim_way_ff <= WAY_W'(victim);
         evicted_ff    <= mask_shift[0];
      end
   end

   assign rsp_victim_way = victim_way_ff;
   assign rsp_evicted    = evicted_ff;

   assign sts.clear_last = (clr_addr_ff == SET_W'(SETS - 1));
   assign sts.is_victim  = is_victim;

endmodule

`default_nettype wire

[rtl/crlru_ctrl.sv]
// Controller: clearing pass, read-modify-write sequencing and response handshake.
`default_nettype none

module crlru_ctrl
   import crlru_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output crlru_cmd_type      cmd,
   input  wire crlru_sts_type sts
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_CALC  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CALC;
            end
         end
         S_CALC: begin
            if (!sts.is_victim) begin
               cmd.update = 1'b1;
               state_in   = S_IDLE;
            end else if (out_free) begin
               cmd.update   = 1'b1;
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Response valid flag of the output register.
   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // A waiting response beat is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("response register overwritten while stalled");

   // Only a victim query loads a response.
   a_rsp_only_victim: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> sts.is_victim)
      else $error("response loaded for a non-victim operation");

   // The clearing pass ends after its last set.
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && sts.clear_last) |=> (state_ff == S_IDLE))
      else $error("clearing pass did not finish");

   // An accepted beat always moves on to the update step.
   a_accept_calc: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_CALC))
      else $error("accepted beat not followed by update step");

   // A write-back only happens in the update step.
   a_update_state: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (state_ff == S_CALC))
      else $error("row update outside the update step");

endmodule

`default_nettype wire
